[rtl/h264dp_pkg.sv]
// Package with item types and NAL constants for the H.264 RTP depacketizer.
package h264dp_pkg;

  // NAL unit type codes
  localparam logic [4:0] NAL_TYPE_FU_A        = 5'd28;
  localparam logic [4:0] NAL_TYPE_SINGLE_LAST = 5'd23;
  localparam logic [4:0] NAL_TYPE_RESERVED    = 5'd0;

  // Results for an item that carries a start code: 00 00 00 01 and one byte
  localparam logic [2:0] START_ITEM_COUNT  = 3'd5;
  localparam logic [2:0] SINGLE_ITEM_COUNT = 3'd1;
  localparam logic [2:0] START_CODE_LAST   = 3'd2;

  // Input item: one RTP payload byte with its packet flags
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       packet_first;
    logic       packet_last;
    logic       marker_bit;
  } rtp_in_t;

  // Output item: one Annex B byte or an empty end marker
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       packet_done;
  } annexb_out_t;

endpackage

[rtl/h264_rtp_payload_depacketizer.sv]
// Top level of the H.264 RTP payload depacketizer (RTP payload to Annex B).
//
// Usage:
//   in_valid/in_ready/in_data carry RTP payload bytes, one per item, with
//   packet_first, packet_last and the packet's marker bit. out_valid/out_ready/
//   out_data carry the Annex B stream, one byte per item, with byte_present
//   (0 on an empty end marker) and packet_done on a packet's final item.
// Timing:
//   An accepted byte is decoded in the same cycle into a result register;
//   its first result is shown on the next cycle. A header byte of a single
//   NAL unit or a starting FU-A fragment yields five results (start code and
//   header) and holds the input until the last of them is taken; every
//   other byte yields at most one result, so plain payload streams at one
//   item per cycle while out_ready is high. The pending count sets the rate.
// Reset:
//   rst clears the pending count and returns the parser to expecting a
//   packet header; saved NRI and marker clear to zero.
// Stall:
//   While out_ready is low, the pending result holds and in_ready drops
//   once the last pending result of the current item waits.
module h264_rtp_payload_depacketizer
  import h264dp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  rtp_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output annexb_out_t out_data
);

  typedef enum logic [1:0] {
    PH_HDR  = 2'd0,
    PH_PASS = 2'd1,
    PH_FUH  = 2'd2,
    PH_STRIP = 2'd3
  } phase_t;

  phase_t     phase, phase_next;
  logic [2:0] saved_f_nri, saved_f_nri_next;
  logic       saved_marker, saved_marker_next;

  // Result register: pending count, final byte and its flags
  logic [2:0] cnt, cnt_next, load_cnt;
  logic [7:0] res_byte, res_byte_next;
  logic       res_present, res_present_next;
  logic       res_done, res_done_next;

  logic       in_acc, out_acc;
  logic       hdr;
  logic [4:0] nal_type;
  logic       emit_start, emit_byte;
  logic [7:0] emit_val;

  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;
  assign in_ready = (cnt == '0) || ((cnt == SINGLE_ITEM_COUNT) && out_ready);
  assign hdr      = in_data.packet_first || (phase == PH_HDR);
  assign nal_type = in_data.payload_byte[4:0];

  // Decode one payload byte against the parser state
  always_comb begin
    phase_next        = phase;
    saved_f_nri_next  = saved_f_nri;
    saved_marker_next = saved_marker;
    emit_start        = 1'b0;
    emit_byte         = 1'b0;
    emit_val          = in_data.payload_byte;
    if (hdr) begin
      saved_marker_next = in_data.marker_bit;
      priority if ((nal_type != NAL_TYPE_RESERVED) && (nal_type <= NAL_TYPE_SINGLE_LAST)) begin
        emit_start = 1'b1;
        emit_byte  = 1'b1;
        phase_next = PH_PASS;
      end else if (nal_type == NAL_TYPE_FU_A) begin
        saved_f_nri_next = in_data.payload_byte[7:5];
        phase_next       = PH_FUH;
      end else begin
        emit_byte  = 1'b1;
        phase_next = PH_PASS;
      end
    end else begin
      unique case (phase)
        PH_FUH: begin
          // rebuild the NAL header on a starting fragment
          if (!saved_marker && in_data.payload_byte[7]) begin
            emit_start = 1'b1;
            emit_byte  = 1'b1;
            emit_val   = {saved_f_nri, nal_type};
          end
          phase_next = PH_PASS;
        end
        default: begin
          emit_byte = 1'b1;
        end
      endcase
    end
    if (in_data.packet_last) begin
      phase_next = PH_HDR;
    end
  end

  // Plan the results of the accepted byte
  always_comb begin
    load_cnt         = '0;
    res_byte_next    = emit_val;
    res_present_next = emit_byte;
    res_done_next    = in_data.packet_last;
    if (emit_start) begin
      load_cnt = START_ITEM_COUNT;
    end else if (emit_byte || in_data.packet_last) begin
      load_cnt = SINGLE_ITEM_COUNT;
    end
    if (!emit_byte) begin
      res_byte_next = '0;
    end
  end

  // Advance the pending count
  always_comb begin
    cnt_next = cnt;
    if (in_acc) begin
      cnt_next = load_cnt;
    end else if (out_acc) begin
      cnt_next = cnt - 3'd1;
    end
  end

  // Hold parser state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR;
      saved_f_nri  <= '0;
      saved_marker <= 1'b0;
      cnt          <= '0;
    end else begin
      cnt <= cnt_next;
      if (in_acc) begin
        phase        <= phase_next;
        saved_f_nri  <= saved_f_nri_next;
        saved_marker <= saved_marker_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_byte    <= res_byte_next;
      res_present <= res_present_next;
      res_done    <= res_done_next;
    end
  end

  // Drive the output item: start code bytes first, then the final result
  assign out_valid = (cnt != '0);
  always_comb begin
    out_data.out_byte     = 8'h00;
    out_data.byte_present = 1'b1;
    out_data.packet_done  = 1'b0;
    if (cnt == SINGLE_ITEM_COUNT) begin
      out_data.out_byte     = res_byte;
      out_data.byte_present = res_present;
      out_data.packet_done  = res_done;
    end else if (cnt == START_CODE_LAST) begin
      out_data.out_byte = 8'h01;
    end
  end

  // Checks
  a_reset_empty: assert property (@(posedge clk) rst |=> (cnt == '0))
    else $error("result register not empty after reset");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= START_ITEM_COUNT)
    else $error("pending count out of range");

  a_empty_is_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.byte_present) |-> out_data.packet_done)
    else $error("empty marker without packet end");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(cnt) && $stable(out_data)))
    else $error("pending result changed during stall");

  a_single_nal_start: assert property (@(posedge clk) disable iff (rst)
    (in_acc && hdr && (nal_type != NAL_TYPE_RESERVED)
     && (nal_type <= NAL_TYPE_SINGLE_LAST)) |=> (cnt == START_ITEM_COUNT))
    else $error("single NAL header did not queue a start code");

endmodule
